// ----- sv/rbmc_pkg.sv -----
`default_nettype none

package rbmc_pkg;

  localparam int RANGE_SLOTS  = 8;
  localparam int BITMAP_BYTES = 4096;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SLOT_W  = $clog2(RANGE_SLOTS);
  localparam int ADDR_W  = $clog2(BITMAP_BYTES);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int WORD_W  = 32;
  localparam int ACT_W   = 4;
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int BIT_W   = 3;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_t;

  // One entry of the queue between the classifier and the bitmap side.
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
    logic [BIT_W-1:0]   bit_sel;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/rbmc_in_if.sv -----
`default_nettype none

interface rbmc_in_if import rbmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [2:0]          range_slot;
  logic [WORD_W-1:0]   range_low;
  logic [WORD_W-1:0]   range_high;
  logic [11:0]         map_base;
  logic [12:0]         map_length;
  logic [11:0]         map_address;
  logic [BYTE_W-1:0]   map_byte;
  logic [WORD_W-1:0]   instruction_word;

  modport source (
    output valid, func, range_slot, range_low, range_high, map_base, map_length,
           map_address, map_byte, instruction_word,
    input  ready
  );
  modport sink (
    input  valid, func, range_slot, range_low, range_high, map_base, map_length,
           map_address, map_byte, instruction_word,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/rbmc_out_if.sv -----
`default_nettype none

interface rbmc_out_if;
  logic valid;
  logic ready;
  logic executable;

  modport source (output valid, executable, input ready);
  modport sink (input valid, executable, output ready);
endinterface

`default_nettype wire

// ----- sv/rbmc_cfg_if.sv -----
`default_nettype none

interface rbmc_cfg_if import rbmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  active_ranges;

  modport source (output valid, active_ranges, input ready);
  modport sink (input valid, active_ranges, output ready);
endinterface

`default_nettype wire

// ----- sv/rbmc_front.sv -----
`default_nettype none

module rbmc_front import rbmc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rbmc_in_if.sink     in_bus,
  rbmc_cfg_if.sink    cfg_bus,
  input  wire logic   q_full,
  output logic        q_push,
  output cmd_t        q_wdata
);

  logic [ACT_W-1:0]  active_r;
  logic [WORD_W-1:0] slot_low_r  [RANGE_SLOTS];
  logic [WORD_W-1:0] slot_high_r [RANGE_SLOTS];
  logic [ADDR_W-1:0] slot_base_r [RANGE_SLOTS];
  logic [LEN_W-1:0]  slot_len_r  [RANGE_SLOTS];

  logic                  accept;
  logic [RANGE_SLOTS-1:0] hit;
  logic [ADDR_W-1:0]     hit_addr [RANGE_SLOTS];
  logic [BIT_W-1:0]      hit_bit  [RANGE_SLOTS];
  logic [ADDR_W-1:0]     sel_addr;
  logic [BIT_W-1:0]      sel_bit;
  logic                  any_hit;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !q_full;
  assign accept        = in_bus.valid && !q_full;
  assign q_push        = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_bus.valid) begin
      active_r <= cfg_bus.active_ranges;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_bus.func == FUNC_RANGE) begin
      slot_low_r[in_bus.range_slot[SLOT_W-1:0]]  <= in_bus.range_low;
      slot_high_r[in_bus.range_slot[SLOT_W-1:0]] <= in_bus.range_high;
      slot_base_r[in_bus.range_slot[SLOT_W-1:0]] <= in_bus.map_base[ADDR_W-1:0];
      slot_len_r[in_bus.range_slot[SLOT_W-1:0]]  <= in_bus.map_length[LEN_W-1:0];
    end
  end

  // One comparator lane per slot; every lane works on the same word.
  always_comb begin
    logic [WORD_W-1:0] offset;
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      offset      = in_bus.instruction_word - slot_low_r[i];
      hit[i]      = (32'(i) < 32'(active_r))
                    && (in_bus.instruction_word >= slot_low_r[i])
                    && (in_bus.instruction_word < slot_high_r[i])
                    && (offset[WORD_W-1:3] < (WORD_W-3)'(slot_len_r[i]));
      hit_addr[i] = slot_base_r[i] + offset[ADDR_W+2:3];
      hit_bit[i]  = offset[BIT_W-1:0];
    end
  end

  // The lowest slot that hits decides.
  always_comb begin
    sel_addr = '0;
    sel_bit  = '0;
    any_hit  = |hit;
    for (int i = RANGE_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel_addr = hit_addr[i];
        sel_bit  = hit_bit[i];
      end
    end
  end

  always_comb begin
    q_wdata.op      = OP_NONE;
    q_wdata.addr    = sel_addr;
    q_wdata.data    = in_bus.map_byte;
    q_wdata.bit_sel = sel_bit;
    unique case (in_bus.func)
      FUNC_BYTE: begin
        q_wdata.op   = OP_WRITE;
        q_wdata.addr = in_bus.map_address[ADDR_W-1:0];
      end
      FUNC_CHECK: begin
        q_wdata.op = any_hit ? OP_READ : OP_NONE;
      end
      default: begin
        q_wdata.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/rbmc_queue.sv -----
`default_nettype none

module rbmc_queue import rbmc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  wdata,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output cmd_t       head
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rbmc_back.sv -----
`default_nettype none

module rbmc_back import rbmc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire cmd_t   q_head,
  output logic        q_pop,
  rbmc_out_if.source  out_bus
);

  logic [BYTE_W-1:0] bitmap_mem [BITMAP_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic              p_valid_r;
  logic              p_read_r;
  logic [BIT_W-1:0]  p_bit_r;
  logic              out_valid_r;
  logic              out_exec_r;

  logic out_free;
  logic p_move;

  assign out_free = !out_valid_r || out_bus.ready;
  assign p_move   = p_valid_r && out_free;
  assign q_pop    = !q_empty && (!p_valid_r || p_move);

  assign out_bus.valid      = out_valid_r;
  assign out_bus.executable = out_exec_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_WRITE) begin
      bitmap_mem[q_head.addr] <= q_head.data;
    end
    if (q_pop && q_head.op == OP_READ) begin
      rd_data_r <= bitmap_mem[q_head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_read_r <= (q_head.op == OP_READ);
      p_bit_r  <= q_head.bit_sel;
    end
    if (p_move) begin
      out_exec_r <= p_read_r && rd_data_r[p_bit_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/range_bitmap_membership_check.sv -----
// Items pass the queue, read and output registers. Throughput: one item per
// cycle unless the output stalls; the bitmap memory's single port takes one
// byte write or one byte read per cycle, and a two-entry queue separates it
// from the range comparators. Reset clears the register, queue and result
// valid; range slots and bitmap bytes hold nothing meaningful until written.
`default_nettype none

module range_bitmap_membership_check import rbmc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rbmc_in_if.sink     in_bus,
  rbmc_out_if.source  out_bus,
  rbmc_cfg_if.sink    cfg_bus
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_head;

  rbmc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  rbmc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  rbmc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

// ----- test/tb_range_bitmap_membership_check.sv -----
`default_nettype none

import rbmc_pkg::*;

localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

typedef struct {
  logic [FUNC_W-1:0] func;
  logic [2:0]        slot;
  logic [WORD_W-1:0] low;
  logic [WORD_W-1:0] high;
  logic [11:0]       base;
  logic [12:0]       length;
  logic [11:0]       address;
  logic [BYTE_W-1:0] data;
  logic [WORD_W-1:0] word;
} lookup_beat_t;

class membership_scoreboard;
  logic [WORD_W-1:0] lo [RANGE_SLOTS];
  logic [WORD_W-1:0] hi [RANGE_SLOTS];
  logic [ADDR_W-1:0] base [RANGE_SLOTS];
  logic [LEN_W-1:0]  len [RANGE_SLOTS];
  logic [BYTE_W-1:0] bitmap [BITMAP_BYTES];
  bit                byte_known [BITMAP_BYTES];
  int unsigned       active;
  bit                executable_q [$];
  int                errors;

  function new();
    active = 0;
    errors = 0;
    foreach (byte_known[a]) byte_known[a] = 1'b0;
  endfunction

  function int unsigned scanned_slots();
    return (active > RANGE_SLOTS) ? RANGE_SLOTS : active;
  endfunction

  // Returns the bitmap address that decides the word, or -1 if no slot does.
  function int locate_map_byte(input logic [WORD_W-1:0] word, output logic [BIT_W-1:0] sel);
    logic [WORD_W-1:0] offset;
    sel = '0;
    for (int i = 0; i < scanned_slots(); i++) begin
      if (word >= lo[i] && word < hi[i]) begin
        offset = word - lo[i];
        if ((offset >> 3) < 32'(len[i])) begin
          sel = offset[BIT_W-1:0];
          return int'((32'(base[i]) + (offset >> 3)) % BITMAP_BYTES);
        end
      end
    end
    return -1;
  endfunction

  function void set_active(input logic [ACT_W-1:0] value);
    active = value;
  endfunction

  function void note_input(input lookup_beat_t it);
    bit               result;
    int               addr;
    logic [BIT_W-1:0] sel;
    result = 1'b0;
    case (it.func)
      FUNC_RANGE: begin
        if (it.slot < RANGE_SLOTS) begin
          lo[it.slot]   = it.low;
          hi[it.slot]   = it.high;
          base[it.slot] = it.base;
          len[it.slot]  = it.length;
        end
      end
      FUNC_BYTE: begin
        bitmap[it.address % BITMAP_BYTES]     = it.data;
        byte_known[it.address % BITMAP_BYTES] = 1'b1;
      end
      FUNC_CHECK: begin
        addr = locate_map_byte(it.word, sel);
        if (addr >= 0) result = bitmap[addr][sel];
      end
      default: result = 1'b0;
    endcase
    executable_q.push_back(result);
  endfunction

  function void check_result(input logic executable);
    bit want;
    if (executable_q.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual %0b", $time, executable);
      errors++;
    end else begin
      want = executable_q.pop_front();
      if (executable !== want) begin
        $display("%0t: executable mismatch, expected %0b, actual %0b", $time, want, executable);
        errors++;
      end
    end
  endfunction

  function int pending();
    return executable_q.size();
  endfunction
endclass

module tb_range_bitmap_membership_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_OFF      = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 12;
  localparam int PHASE_BEATS   = 128;

  logic clk = 1'b0;
  logic rst_n;

  rbmc_in_if  in_bus ();
  rbmc_out_if out_bus ();
  rbmc_cfg_if cfg_bus ();

  range_bitmap_membership_check u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  membership_scoreboard sb = new();
  bit hold_off_req = 1'b0;
  bit no_gaps = 1'b0;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic lookup_beat_t noise_beat();
    lookup_beat_t it;
    it.func    = FUNC_UNUSED;
    it.slot    = 3'($urandom_range(0, 7));
    it.low     = $urandom;
    it.high    = $urandom;
    it.base    = 12'($urandom_range(0, 4095));
    it.length  = 13'($urandom_range(0, 4096));
    it.address = 12'($urandom_range(0, 4095));
    it.data    = 8'($urandom_range(0, 255));
    it.word    = $urandom;
    return it;
  endfunction

  task automatic send_beat(input lookup_beat_t it);
    int gap;
    @(negedge clk);
    in_bus.func             <= it.func;
    in_bus.range_slot       <= it.slot;
    in_bus.range_low        <= it.low;
    in_bus.range_high       <= it.high;
    in_bus.map_base         <= it.base;
    in_bus.map_length       <= it.length;
    in_bus.map_address      <= it.address;
    in_bus.map_byte         <= it.data;
    in_bus.instruction_word <= it.word;
    in_bus.valid            <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(it);
    gap = gap_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_range(input logic [2:0] slot, input logic [WORD_W-1:0] low,
                            input logic [WORD_W-1:0] high, input logic [11:0] base,
                            input logic [12:0] length);
    lookup_beat_t it;
    it        = noise_beat();
    it.func   = FUNC_RANGE;
    it.slot   = slot;
    it.low    = low;
    it.high   = high;
    it.base   = base;
    it.length = length;
    send_beat(it);
  endtask

  task automatic send_byte(input logic [11:0] address, input logic [BYTE_W-1:0] data);
    lookup_beat_t it;
    it         = noise_beat();
    it.func    = FUNC_BYTE;
    it.address = address;
    it.data    = data;
    send_beat(it);
  endtask

  // A map byte is never read before it is written, so an unwritten deciding
  // byte gets a write of its own just ahead of the check.
  task automatic send_check(input logic [WORD_W-1:0] word);
    lookup_beat_t     it;
    int               addr;
    logic [BIT_W-1:0] sel;
    addr = sb.locate_map_byte(word, sel);
    if (addr >= 0 && !sb.byte_known[addr])
      send_byte(12'(addr), 8'($urandom_range(0, 255)));
    it      = noise_beat();
    it.func = FUNC_CHECK;
    it.word = word;
    send_beat(it);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_bus.active_ranges <= value;
    cfg_bus.valid         <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_active(value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_range_beat();
    logic [2:0]        slot;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
    logic [11:0]       base;
    logic [12:0]       length;
    logic [WORD_W:0]   top;
    int                k;
    slot = 3'($urandom_range(0, 7));
    k = $urandom_range(0, 99);
    if (k < 10) length = 13'd0;
    else if (k < 20) length = 13'd4096;
    else if (k < 70) length = 13'($urandom_range(1, 16));
    else length = 13'($urandom_range(17, 4095));
    base = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(4080, 4095))
                                       : 12'($urandom_range(0, 4095));
    k = $urandom_range(0, 99);
    if (k < 10) low = $urandom_range(0, 64);
    else if (k < 20) low = 32'hFFFF_FFFF - $urandom_range(0, 600);
    else if (k < 40) low = sb.lo[$urandom_range(0, 7)] + $urandom_range(0, 32);
    else low = $urandom;
    top  = {1'b0, low} + 33'($urandom_range(0, 8 * int'(length) + 32));
    high = top[WORD_W] ? 32'hFFFF_FFFF : top[WORD_W-1:0];
    // Now and then an empty or inverted range.
    if ($urandom_range(0, 9) == 0) high = low - $urandom_range(0, 50);
    send_range(slot, low, high, base, length);
  endtask

  task automatic random_byte_beat();
    logic [11:0]       address;
    logic [BYTE_W-1:0] data;
    int                i;
    int                k;
    i = $urandom_range(0, RANGE_SLOTS - 1);
    if (sb.scanned_slots() > 0 && $urandom_range(0, 9) < 6)
      address = sb.base[i] + 12'($urandom_range(0, int'(sb.len[i])));
    else
      address = 12'($urandom_range(0, 4095));
    k = $urandom_range(0, 99);
    data = (k < 15) ? 8'h00 : (k < 30) ? 8'hFF : 8'($urandom_range(0, 255));
    send_byte(address, data);
  endtask

  task automatic random_check_beat();
    logic [WORD_W-1:0] word;
    int                i;
    int                k;
    k = $urandom_range(0, 99);
    if (sb.scanned_slots() > 0 && k < 80) begin
      i = $urandom_range(0, sb.scanned_slots() - 1);
      if (k < 60) word = sb.lo[i] + $urandom_range(0, 8 * int'(sb.len[i]) + 16);
      else if (k < 67) word = sb.lo[i];
      else if (k < 74) word = sb.hi[i] - 1;
      else word = sb.hi[i];
    end else if (k < 88) begin
      word = $urandom;
    end else begin
      word = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    end
    send_check(word);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.executable);
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("range_bitmap_membership_check verification failed");
        $finish;
      end
    end
  end

  initial begin
    int run;
    int r;
    bit level;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF) @(negedge clk) out_bus.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          run = $urandom_range(50, 150);
          level = 1'b1;
        end else if (r < 55) begin
          run = $urandom_range(1, 8);
          level = 1'b1;
        end else if (r < 95) begin
          run = $urandom_range(1, 3);
          level = 1'b0;
        end else begin
          run = $urandom_range(10, 40);
          level = 1'b0;
        end
        repeat (run) @(negedge clk) out_bus.ready <= level;
      end
    end
  end

  initial begin
    lookup_beat_t it;
    logic [ACT_W-1:0] phase_active [PHASES];
    int k;
    phase_active = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2, 4'd7, 4'd12, 4'd4, 4'd8};
    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.func             = FUNC_RANGE;
    in_bus.range_slot       = '0;
    in_bus.range_low        = '0;
    in_bus.range_high       = '0;
    in_bus.map_base         = '0;
    in_bus.map_length       = '0;
    in_bus.map_address      = '0;
    in_bus.map_byte         = '0;
    in_bus.instruction_word = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.active_ranges   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With no active ranges, checks read nothing and answer 0.
    send_beat(noise_beat());
    send_check(32'h0);
    send_check(32'hFFFF_FFFF);
    // Slot 0 wraps around the end of the map memory, slot 1 is inverted,
    // slot 2 empty, slot 3 has no map, slot 4 a map shorter than its range,
    // slot 5 the longest map at the top of the word space.
    send_range(3'd0, 32'd0, 32'd64, 12'd4094, 13'd4);
    send_range(3'd1, 32'd100, 32'd50, 12'd10, 13'd8);
    send_range(3'd2, 32'd200, 32'd200, 12'd20, 13'd8);
    send_range(3'd3, 32'd0, 32'd2000, 12'd100, 13'd0);
    send_range(3'd4, 32'd64, 32'd400, 12'd300, 13'd2);
    send_range(3'd5, 32'hFFFF_FF00, 32'hFFFF_FFFF, 12'd4000, 13'd4096);
    send_range(3'd6, 32'd80, 32'd96, 12'd500, 13'd2);
    send_range(3'd7, 32'd1000, 32'd1001, 12'd4095, 13'd1);
    send_byte(12'd4094, 8'hA5);
    send_byte(12'd4095, 8'h00);
    send_byte(12'd0, 8'hFF);
    write_active(4'd8);
    send_check(32'd2);
    send_check(32'd20);
    send_check(32'd63);
    send_check(32'd64);
    send_check(32'd85);
    send_check(32'd120);
    send_check(32'd75);
    send_check(32'd200);
    send_check(32'hFFFF_FFFE);
    send_check(32'hFFFF_FFFF);
    send_check(32'd1000);

    for (int p = 0; p < PHASES; p++) begin
      write_active(phase_active[p]);
      no_gaps = (p == 1 || p == 6);
      // The receiver stops for a long stretch while beats keep coming.
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          random_check_beat();
        end else if (k < 83) begin
          random_byte_beat();
        end else if (k < 96) begin
          random_range_beat();
        end else begin
          it = noise_beat();
          send_beat(it);
        end
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("range_bitmap_membership_check verification clean");
    end else begin
      $display("range_bitmap_membership_check verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- range_bitmap_membership_check.f -----
sv/rbmc_pkg.sv
sv/rbmc_in_if.sv
sv/rbmc_out_if.sv
sv/rbmc_cfg_if.sv
sv/rbmc_front.sv
sv/rbmc_queue.sv
sv/rbmc_back.sv
sv/range_bitmap_membership_check.sv
test/tb_range_bitmap_membership_check.sv
